// ===== design/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
    lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
        else $error("assertion failed: invariant");

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== design/gtt_pkg.sv =====
// Types, constants and character classes shared by the tokenizer modules.
`default_nettype none

package gtt_pkg;

    localparam int D_LINE_BITS   = 16;
    localparam int D_COL_BITS    = 16;
    localparam int D_OFFSET_BITS = 20;
    localparam int D_LENGTH_BITS = 16;

    localparam int W_KIND = 4;
    localparam int W_LINE = 16;
    localparam int W_COL  = 16;
    localparam int W_OFF  = 20;
    localparam int W_LEN  = 16;

    localparam int Q_DEPTH = 4;

    localparam logic [W_KIND-1:0] K_END    = 4'd0;
    localparam logic [W_KIND-1:0] K_SYMBOL = 4'd1;
    localparam logic [W_KIND-1:0] K_NUMBER = 4'd2;
    localparam logic [W_KIND-1:0] K_ARROW  = 4'd3;
    localparam logic [W_KIND-1:0] K_LBRACE = 4'd4;
    localparam logic [W_KIND-1:0] K_RBRACE = 4'd5;
    localparam logic [W_KIND-1:0] K_LPAREN = 4'd6;
    localparam logic [W_KIND-1:0] K_RPAREN = 4'd7;
    localparam logic [W_KIND-1:0] K_COLON  = 4'd8;
    localparam logic [W_KIND-1:0] K_BAR    = 4'd9;
    localparam logic [W_KIND-1:0] K_STAR   = 4'd10;
    localparam logic [W_KIND-1:0] K_TILDE  = 4'd11;
    localparam logic [W_KIND-1:0] K_QUOTE  = 4'd12;
    localparam logic [W_KIND-1:0] K_COMMA  = 4'd13;
    localparam logic [W_KIND-1:0] K_ERROR  = 4'd14;
    localparam logic [W_KIND-1:0] K_NONE   = 4'd0;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    typedef enum logic [3:0] {
        M_IDLE,
        M_SYMBOL,
        M_NUM_INT,
        M_NUM_FRAC,
        M_MINUS,
        M_MINUS2,
        M_MINUS_DOT,
        M_DOT,
        M_SLASH,
        M_COMMENT,
        M_DISCARD
    } t_mode;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
    } t_in;

    typedef struct packed {
        logic [W_KIND-1:0] kind;
        logic [W_LINE-1:0] tok_line;
        logic [W_COL-1:0]  tok_col;
        logic [W_OFF-1:0]  tok_offset;
        logic [W_LEN-1:0]  tok_length;
        logic              last_of_run;
    } t_out;

    typedef struct packed {
        logic [1:0] count;
        t_out       first;
        t_out       second;
    } t_pair;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, [8'h09:8'h0D]};
    endfunction

    function automatic logic [W_KIND-1:0] punct_kind(input logic [7:0] c);
        logic [W_KIND-1:0] k;
        case (c)
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_COLON:  k = K_COLON;
            CH_BAR:    k = K_BAR;
            CH_STAR:   k = K_STAR;
            CH_TILDE:  k = K_TILDE;
            CH_QUOTE:  k = K_QUOTE;
            CH_COMMA:  k = K_COMMA;
            default:   k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== design/gtt_scan.sv =====
// Scanner: position counters, scan state and up to two tokens per accepted byte.
`default_nettype none
`include "assert_macros.svh"

module gtt_scan #(
    parameter int LINE_BITS   = gtt_pkg::D_LINE_BITS,
    parameter int COL_BITS    = gtt_pkg::D_COL_BITS,
    parameter int OFFSET_BITS = gtt_pkg::D_OFFSET_BITS,
    parameter int LENGTH_BITS = gtt_pkg::D_LENGTH_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  gtt_pkg::t_in  i_in,
    output gtt_pkg::t_pair o_pair
);
    import gtt_pkg::*;

    t_mode                  r_mode, n_mode;
    logic [LINE_BITS-1:0]   r_line, n_line, r_sline, n_sline;
    logic [COL_BITS-1:0]    r_col, n_col, r_scol, n_scol;
    logic [OFFSET_BITS-1:0] r_off, n_off, r_soff, n_soff;
    logic [LENGTH_BITS-1:0] r_len, n_len;

    logic [7:0]             ch;
    logic                   c_dig, c_dot, c_minus, c_slash, c_gt, c_nl, c_word;
    logic                   id_begin, id_punct, id_err;
    t_mode                  id_mode;
    logic [W_KIND-1:0]      id_kind;
    logic [LENGTH_BITS-1:0] len_inc;

    always_comb begin
        ch       = i_in.ch;
        c_dig    = is_digit(ch);
        c_dot    = (ch == CH_DOT);
        c_minus  = (ch == CH_MINUS);
        c_slash  = (ch == CH_SLASH);
        c_gt     = (ch == CH_GT);
        c_nl     = (ch == CH_NL);
        c_word   = is_word(ch);
        id_kind  = punct_kind(ch);
        id_begin = c_slash || c_minus || c_dot || c_dig || is_alpha(ch) || (ch == CH_UNDER);
        id_punct = (id_kind != K_NONE);
        id_err   = 1'b0;
        if (is_space(ch)) begin
            id_mode = M_IDLE;
        end else if (ch == CH_HASH) begin
            id_mode = M_COMMENT;
        end else if (c_slash) begin
            id_mode = M_SLASH;
        end else if (c_minus) begin
            id_mode = M_MINUS;
        end else if (c_dot) begin
            id_mode = M_DOT;
        end else if (c_dig) begin
            id_mode = M_NUM_INT;
        end else if (c_word) begin
            id_mode = M_SYMBOL;
        end else if (id_punct) begin
            id_mode = M_IDLE;
        end else begin
            id_mode = M_DISCARD;
            id_err  = 1'b1;
        end
        len_inc = (r_len == '1) ? r_len : r_len + LENGTH_BITS'(1);
    end

    // Next state of the scan mode, the token start and the position counters.
    always_comb begin
        logic use_idle;
        logic grow;
        use_idle = 1'b0;
        grow     = 1'b0;
        n_mode   = r_mode;
        n_sline  = r_sline;
        n_scol   = r_scol;
        n_soff   = r_soff;
        n_len    = r_len;
        n_line   = r_line;
        n_col    = r_col;
        n_off    = r_off;
        if (i_accept) begin
            if (i_in.cmd) begin
                n_mode  = M_IDLE;
                n_sline = LINE_BITS'(1);
                n_scol  = COL_BITS'(1);
                n_soff  = '0;
                n_len   = '0;
                n_line  = LINE_BITS'(1);
                n_col   = COL_BITS'(1);
                n_off   = '0;
            end else begin
                case (r_mode)
                    M_IDLE: begin
                        use_idle = 1'b1;
                    end
                    M_SYMBOL: begin
                        if (c_word) grow = 1'b1;
                        else use_idle = 1'b1;
                    end
                    M_NUM_INT: begin
                        if (c_dig) begin
                            grow = 1'b1;
                        end else if (c_dot) begin
                            grow   = 1'b1;
                            n_mode = M_NUM_FRAC;
                        end else begin
                            use_idle = 1'b1;
                        end
                    end
                    M_NUM_FRAC: begin
                        if (c_dig) grow = 1'b1;
                        else use_idle = 1'b1;
                    end
                    M_MINUS: begin
                        grow = 1'b1;
                        if (c_minus) begin
                            n_mode = M_MINUS2;
                        end else if (c_gt) begin
                            n_mode = M_IDLE;
                        end else if (c_dig) begin
                            n_mode = M_NUM_INT;
                        end else if (c_dot) begin
                            n_mode = M_MINUS_DOT;
                        end else begin
                            grow   = 1'b0;
                            n_mode = M_DISCARD;
                        end
                    end
                    M_MINUS2: begin
                        if (c_gt) begin
                            grow   = 1'b1;
                            n_mode = M_IDLE;
                        end else begin
                            n_mode = M_DISCARD;
                        end
                    end
                    M_MINUS_DOT, M_DOT: begin
                        if (c_dig) begin
                            grow   = 1'b1;
                            n_mode = M_NUM_FRAC;
                        end else begin
                            n_mode = M_DISCARD;
                        end
                    end
                    M_SLASH: begin
                        n_mode = c_slash ? M_COMMENT : M_DISCARD;
                    end
                    M_COMMENT: begin
                        if (c_nl) n_mode = M_IDLE;
                    end
                    default: begin
                        n_mode = M_DISCARD;
                    end
                endcase
                if (grow) n_len = len_inc;
                if (use_idle) begin
                    n_mode = id_mode;
                    if (id_begin) begin
                        n_sline = r_line;
                        n_scol  = r_col;
                        n_soff  = r_off;
                        n_len   = LENGTH_BITS'(1);
                    end
                end
                if (c_nl) begin
                    n_line = (r_line == '1) ? r_line : r_line + LINE_BITS'(1);
                    n_col  = COL_BITS'(1);
                end else begin
                    n_col  = (r_col == '1) ? r_col : r_col + COL_BITS'(1);
                end
                n_off = (r_off == '1) ? r_off : r_off + OFFSET_BITS'(1);
            end
        end
    end

    // Results: a held token from the start registers, then one at the current position.
    always_comb begin
        logic                   use_idle;
        logic                   held_v, cur_v;
        logic [W_KIND-1:0]      held_k, cur_k;
        logic [LENGTH_BITS-1:0] held_l;
        logic                   cur_one;
        t_out                   held, cur;
        use_idle = 1'b0;
        held_v   = 1'b0;
        cur_v    = 1'b0;
        held_k   = K_ERROR;
        cur_k    = K_END;
        held_l   = '0;
        cur_one  = 1'b0;
        if (i_accept) begin
            if (i_in.cmd) begin
                case (r_mode)
                    M_SYMBOL: begin
                        held_v = 1'b1;
                        held_k = K_SYMBOL;
                        held_l = r_len;
                        cur_v  = 1'b1;
                    end
                    M_NUM_INT, M_NUM_FRAC: begin
                        held_v = 1'b1;
                        held_k = K_NUMBER;
                        held_l = r_len;
                        cur_v  = 1'b1;
                    end
                    M_MINUS, M_MINUS2, M_MINUS_DOT, M_DOT, M_SLASH: begin
                        held_v = 1'b1;
                    end
                    M_IDLE, M_COMMENT: begin
                        cur_v = 1'b1;
                    end
                    default: begin
                        held_v = 1'b0;
                    end
                endcase
            end else begin
                case (r_mode)
                    M_IDLE: begin
                        use_idle = 1'b1;
                    end
                    M_SYMBOL: begin
                        if (!c_word) begin
                            held_v   = 1'b1;
                            held_k   = K_SYMBOL;
                            held_l   = r_len;
                            use_idle = 1'b1;
                        end
                    end
                    M_NUM_INT: begin
                        if (!c_dig && !c_dot) begin
                            held_v   = 1'b1;
                            held_k   = K_NUMBER;
                            held_l   = r_len;
                            use_idle = 1'b1;
                        end
                    end
                    M_NUM_FRAC: begin
                        if (!c_dig) begin
                            held_v   = 1'b1;
                            held_k   = K_NUMBER;
                            held_l   = r_len;
                            use_idle = 1'b1;
                        end
                    end
                    M_MINUS: begin
                        if (c_gt) begin
                            held_v = 1'b1;
                            held_k = K_ARROW;
                            held_l = len_inc;
                        end else if (!c_minus && !c_dig && !c_dot) begin
                            held_v = 1'b1;
                        end
                    end
                    M_MINUS2: begin
                        held_v = 1'b1;
                        if (c_gt) begin
                            held_k = K_ARROW;
                            held_l = len_inc;
                        end
                    end
                    M_MINUS_DOT, M_DOT: begin
                        held_v = !c_dig;
                    end
                    M_SLASH: begin
                        held_v = !c_slash;
                    end
                    default: begin
                        held_v = 1'b0;
                    end
                endcase
                if (use_idle) begin
                    if (id_punct) begin
                        cur_v   = 1'b1;
                        cur_k   = id_kind;
                        cur_one = 1'b1;
                    end else if (id_err) begin
                        cur_v = 1'b1;
                        cur_k = K_ERROR;
                    end
                end
            end
        end

        held.kind        = held_k;
        held.tok_line    = W_LINE'(r_sline);
        held.tok_col     = W_COL'(r_scol);
        held.tok_offset  = W_OFF'(r_soff);
        held.tok_length  = W_LEN'(held_l);
        held.last_of_run = !cur_v;

        cur.kind         = cur_k;
        cur.tok_line     = W_LINE'(r_line);
        cur.tok_col      = W_COL'(r_col);
        cur.tok_offset   = W_OFF'(r_off);
        cur.tok_length   = cur_one ? W_LEN'(1) : '0;
        cur.last_of_run  = 1'b1;

        o_pair.count  = {1'b0, held_v} + {1'b0, cur_v};
        o_pair.first  = held_v ? held : cur;
        o_pair.second = cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= LINE_BITS'(1);
            r_col   <= COL_BITS'(1);
            r_off   <= '0;
            r_sline <= LINE_BITS'(1);
            r_scol  <= COL_BITS'(1);
            r_soff  <= '0;
            r_len   <= '0;
        end else begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_off   <= n_off;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_soff  <= n_soff;
            r_len   <= n_len;
        end
    end

    `ASSERT_NEXT(a_text_restart, i_clk, !i_rst_n, i_accept && i_in.cmd,
        r_mode == M_IDLE && r_line == LINE_BITS'(1) && r_off == '0)
    `ASSERT_IMPLY(a_discard_quiet, i_clk, !i_rst_n, r_mode == M_DISCARD,
        o_pair.count == 2'd0)
    `ASSERT_NEXT(a_error_stops, i_clk, !i_rst_n,
        i_accept && !i_in.cmd && o_pair.count != 2'd0 && o_pair.first.kind == K_ERROR,
        r_mode == M_DISCARD)

endmodule

`default_nettype wire

// ===== design/gtt_outq.sv =====
// Result queue: takes up to two tokens per cycle and hands out one per transaction.
`default_nettype none
`include "assert_macros.svh"

module gtt_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gtt_pkg::t_pair i_pair,
    input  logic           i_out_stall,
    output logic           o_full,
    output logic           o_valid,
    output gtt_pkg::t_out  o_data
);
    import gtt_pkg::*;

    localparam int CW = $clog2(Q_DEPTH + 1);

    t_out          r_q [Q_DEPTH];
    t_out          n_q [Q_DEPTH];
    logic [CW-1:0] r_count, n_count;
    logic          pop;
    logic [CW-1:0] base;

    always_comb begin
        pop     = (r_count != '0) && !i_out_stall;
        base    = r_count - CW'(pop);
        n_count = base + CW'(i_pair.count);
        for (int k = 0; k < Q_DEPTH - 1; k++) begin
            n_q[k] = pop ? r_q[k + 1] : r_q[k];
        end
        n_q[Q_DEPTH - 1] = r_q[Q_DEPTH - 1];
        for (int k = 0; k < Q_DEPTH; k++) begin
            if (i_pair.count != 2'd0 && base == CW'(k)) begin
                n_q[k] = i_pair.first;
            end
            if (i_pair.count == 2'd2 && base + CW'(1) == CW'(k)) begin
                n_q[k] = i_pair.second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Q_DEPTH; k++) begin
            r_q[k] <= n_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_full  = r_count > CW'(Q_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_data  = r_q[0];

    `ASSERT_ALWAYS(a_count_max, i_clk, !i_rst_n, r_count <= CW'(Q_DEPTH))
    `ASSERT_IMPLY(a_push_room, i_clk, !i_rst_n, i_pair.count != 2'd0,
        r_count <= CW'(Q_DEPTH - 2))
    `ASSERT_IMPLY(a_pair_whole, i_clk, !i_rst_n, o_valid && !r_q[0].last_of_run,
        r_count >= CW'(2))

endmodule

`default_nettype wire

// ===== design/grammar_text_tokenizer.sv =====
// Top level of the grammar text tokenizer: scanner followed by the result queue.
// A byte is taken in the cycle it is accepted; its tokens are registered in the result queue.
// One byte per cycle is sustained while tokens are taken and the queue is not full; a
// byte that closes a token and starts a punctuation, error or end token yields two output transactions.
// Input stalls while the four-entry result queue has room for fewer than two tokens.
// Synchronous active-low reset returns the scanner to line 1, column 1, offset 0 and empties the queue.
`default_nettype none

module grammar_text_tokenizer #(
    parameter int LINE_BITS   = gtt_pkg::D_LINE_BITS,
    parameter int COL_BITS    = gtt_pkg::D_COL_BITS,
    parameter int OFFSET_BITS = gtt_pkg::D_OFFSET_BITS,
    parameter int LENGTH_BITS = gtt_pkg::D_LENGTH_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  gtt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output gtt_pkg::t_out o_out_data
);
    import gtt_pkg::*;

    logic  accept;
    t_pair pair;
    logic  full;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    gtt_scan #(
        .LINE_BITS  (LINE_BITS),
        .COL_BITS   (COL_BITS),
        .OFFSET_BITS(OFFSET_BITS),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_in    (i_in_data),
        .o_pair  (pair)
    );

    gtt_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pair     (pair),
        .i_out_stall(i_out_stall),
        .o_full     (full),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data)
    );

endmodule

`default_nettype wire
